// ----- sv/h2r_pkg.sv -----
// Shared types, constants and lookup tables for the HSV to RGB converter.
// Used by hsv_to_rgb_converter; depends on nothing else.
`default_nettype none

package h2r_pkg;

	// Fixed-point format: 1.0 is 1 << FRAC_BITS. Saturation, value and the
	// p, q and t terms can reach exactly 1.0, so they carry one extra bit.
	localparam int FRAC_BITS  = 16;
	localparam int FX_W       = FRAC_BITS + 1;
	localparam int FX_ONE_INT = 1 << FRAC_BITS;
	localparam logic [FX_W-1:0] FX_ONE = FX_W'(FX_ONE_INT);

	localparam int PCT_FULL   = 100;
	localparam int HUE_SECTOR = 60;
	localparam int HUE_WRAP   = 360;
	localparam int BYTE_MAX   = 255;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
		logic [7:0] alpha_in;
	} h2r_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} h2r_out_t;

	typedef logic [FX_W-1:0]      pct_lut_t [0:PCT_FULL];
	typedef logic [FRAC_BITS-1:0] ff_lut_t  [0:HUE_SECTOR-1];

	// floor(pct * 1.0 / 100) for every percentage, built at elaboration.
	function automatic pct_lut_t build_pct_lut();
		pct_lut_t lut;
		for (int i = 0; i <= PCT_FULL; i++) begin
			lut[i] = FX_W'((i * FX_ONE_INT) / PCT_FULL);
		end
		return lut;
	endfunction

	// floor(rem * 1.0 / 60) for every offset inside a hue sector.
	function automatic ff_lut_t build_ff_lut();
		ff_lut_t lut;
		for (int i = 0; i < HUE_SECTOR; i++) begin
			lut[i] = FRAC_BITS'((i * FX_ONE_INT) / HUE_SECTOR);
		end
		return lut;
	endfunction

endpackage

`default_nettype wire

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB converter top level: a four-stage pipeline with an output register.
// Depends on h2r_pkg for the beat structs, the fixed-point format and the tables.
`default_nettype none

// One color enters per clock cycle while in_ready is high, and its result passes
// through table lookup and hue sector, products with saturation, products with value,
// then channel selection and scaling to 0..255 into the output register. The
// two rows of 17 by 17 bit multipliers set the stage depth. A full pipeline
// holds four beats; when out_ready drops, stages that hold a beat stall while
// empty stages ahead of them keep filling, so in_ready stays high until every
// stage is occupied. Alpha travels alongside unchanged.
module hsv_to_rgb_converter import h2r_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire h2r_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output h2r_out_t      out_data
);

	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} sector_t;

	localparam pct_lut_t PCT_LUT = build_pct_lut();
	localparam ff_lut_t  FF_LUT  = build_ff_lut();
	localparam int       PROD_W  = 2 * FX_W;
	localparam int       BYTE_W  = FX_W + 8;

	// Stage valid bits and advance enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !vld_s4 || out_ready;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// ---------------- Stage 1: percent scaling, hue sector and fraction
	logic [6:0]          sat_pct, val_pct;
	logic [8:0]          hue_w;
	logic [5:0]          hue_rem;
	sector_t             sec_c;

	always_comb begin
		sat_pct = (in_data.saturation > 7'(PCT_FULL)) ? 7'(PCT_FULL) : in_data.saturation;
		val_pct = (in_data.brightness > 7'(PCT_FULL)) ? 7'(PCT_FULL) : in_data.brightness;
		hue_w   = (in_data.hue >= 9'(HUE_WRAP)) ? 9'd0 : in_data.hue;
		priority if (hue_w < 9'(HUE_SECTOR)) begin
			sec_c   = SEC_RED_YEL;
			hue_rem = hue_w[5:0];
		end else if (hue_w < 9'(2 * HUE_SECTOR)) begin
			sec_c   = SEC_YEL_GRN;
			hue_rem = 6'(hue_w - 9'(HUE_SECTOR));
		end else if (hue_w < 9'(3 * HUE_SECTOR)) begin
			sec_c   = SEC_GRN_CYN;
			hue_rem = 6'(hue_w - 9'(2 * HUE_SECTOR));
		end else if (hue_w < 9'(4 * HUE_SECTOR)) begin
			sec_c   = SEC_CYN_BLU;
			hue_rem = 6'(hue_w - 9'(3 * HUE_SECTOR));
		end else if (hue_w < 9'(5 * HUE_SECTOR)) begin
			sec_c   = SEC_BLU_MAG;
			hue_rem = 6'(hue_w - 9'(4 * HUE_SECTOR));
		end else begin
			sec_c   = SEC_MAG_RED;
			hue_rem = 6'(hue_w - 9'(5 * HUE_SECTOR));
		end
	end

	logic [FX_W-1:0]      s_s1, v_s1;
	logic [FRAC_BITS-1:0] ff_s1;
	sector_t              sec_s1;
	logic                 gray_s1;
	logic [7:0]           alpha_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			s_s1     <= PCT_LUT[sat_pct];
			v_s1     <= PCT_LUT[val_pct];
			ff_s1    <= FF_LUT[hue_rem];
			sec_s1   <= sec_c;
			gray_s1  <= (in_data.saturation == 7'd0);
			alpha_s1 <= in_data.alpha_in;
		end
	end

	// ---------------- Stage 2: saturation times the hue fraction
	logic [PROD_W-1:0] sff_prod, sfc_prod;
	logic [FX_W-1:0]   ff_ext;

	always_comb begin
		ff_ext   = FX_W'(ff_s1);
		sff_prod = PROD_W'(s_s1) * PROD_W'(ff_ext);
		sfc_prod = PROD_W'(s_s1) * PROD_W'(FX_ONE - ff_ext);
	end

	logic [FX_W-1:0] oms_s2, omq_s2, omt_s2, v_s2;
	sector_t         sec_s2;
	logic            gray_s2;
	logic [7:0]      alpha_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			oms_s2   <= FX_ONE - s_s1;
			omq_s2   <= FX_ONE - FX_W'(sff_prod >> FRAC_BITS);
			omt_s2   <= FX_ONE - FX_W'(sfc_prod >> FRAC_BITS);
			v_s2     <= v_s1;
			sec_s2   <= sec_s1;
			gray_s2  <= gray_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// ---------------- Stage 3: value times the three factors
	logic [PROD_W-1:0] p_prod, q_prod, t_prod;

	always_comb begin
		p_prod = PROD_W'(v_s2) * PROD_W'(oms_s2);
		q_prod = PROD_W'(v_s2) * PROD_W'(omq_s2);
		t_prod = PROD_W'(v_s2) * PROD_W'(omt_s2);
	end

	logic [FX_W-1:0] p_s3, q_s3, t_s3, v_s3;
	sector_t         sec_s3;
	logic            gray_s3;
	logic [7:0]      alpha_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p_s3     <= FX_W'(p_prod >> FRAC_BITS);
			q_s3     <= FX_W'(q_prod >> FRAC_BITS);
			t_s3     <= FX_W'(t_prod >> FRAC_BITS);
			v_s3     <= v_s2;
			sec_s3   <= sec_s2;
			gray_s3  <= gray_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// ---------------- Stage 4: per-sector selection and scaling to a byte
	logic [FX_W-1:0] r_fx, g_fx, b_fx;

	always_comb begin
		if (gray_s3) begin
			r_fx = v_s3;
			g_fx = v_s3;
			b_fx = v_s3;
		end else begin
			unique case (sec_s3)
				SEC_RED_YEL: begin r_fx = v_s3; g_fx = t_s3; b_fx = p_s3; end
				SEC_YEL_GRN: begin r_fx = q_s3; g_fx = v_s3; b_fx = p_s3; end
				SEC_GRN_CYN: begin r_fx = p_s3; g_fx = v_s3; b_fx = t_s3; end
				SEC_CYN_BLU: begin r_fx = p_s3; g_fx = q_s3; b_fx = v_s3; end
				SEC_BLU_MAG: begin r_fx = t_s3; g_fx = p_s3; b_fx = v_s3; end
				default:     begin r_fx = v_s3; g_fx = p_s3; b_fx = q_s3; end
			endcase
		end
	end

	// Multiply by 255 as a shift and subtract, drop the fraction, clip at 255.
	function automatic logic [7:0] fx_to_byte(input logic [FX_W-1:0] x);
		logic [BYTE_W-1:0] scaled;
		logic [BYTE_W-FRAC_BITS-1:0] whole;
		scaled = {x, 8'd0} - BYTE_W'(x);
		whole  = (BYTE_W-FRAC_BITS)'(scaled >> FRAC_BITS);
		return (whole > (BYTE_W-FRAC_BITS)'(BYTE_MAX)) ? 8'(BYTE_MAX) : whole[7:0];
	endfunction

	h2r_out_t res_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4.red       <= fx_to_byte(r_fx);
			res_s4.green     <= fx_to_byte(g_fx);
			res_s4.blue      <= fx_to_byte(b_fx);
			res_s4.alpha_out <= alpha_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = res_s4;

	// ---------------- Checks
	// With the sink taking every beat, no stage can block the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the output side was ready");

	// A beat held in stage 2 by a stall stays there.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en_s3) |=> (vld_s2 && $stable(v_s2) && $stable(alpha_s2)))
		else $error("stage 2 beat lost during a stall");

	// p is the floor of the three terms and none of them exceeds value.
	a_term_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (p_s3 <= q_s3 && p_s3 <= t_s3 && q_s3 <= v_s3 && t_s3 <= v_s3))
		else $error("HSV terms out of order");

endmodule

`default_nettype wire
